>>> hw/rtl/oipa_pkg.sv
// shared types and constants for the owned id pool allocator
package oipa_pkg;

    // default pool size and fixed field widths
    localparam int NUM_SLOTS_DEF = 32;
    localparam int SLOT_IDX_W    = 5;
    localparam int GRANT_W       = 5;
    localparam int CTX_W         = 32;
    localparam int OWNER_W       = 20;

    // request kinds
    typedef enum logic [1:0] {
        KIND_GRAB          = 2'd0,
        KIND_RELEASE       = 2'd1,
        KIND_RELEASE_OWNER = 2'd2,
        KIND_INVALID       = 2'd3
    } t_kind;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    // request word
    typedef struct packed {
        t_kind                 kind;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [CTX_W-1:0]      context_tag;
        logic [OWNER_W-1:0]    owner_tag;
    } t_req;

    // result word
    typedef struct packed {
        logic [GRANT_W-1:0] granted_slot;
        t_status            status;
    } t_rsp;

    // command from the request stage to the slot file
    typedef struct packed {
        logic                  grab;
        logic                  rel;
        logic                  rel_own;
        logic [SLOT_IDX_W-1:0] idx;
        logic [CTX_W-1:0]      ctx;
        logic [OWNER_W-1:0]    owner;
    } t_slot_cmd;

endpackage

>>> hw/rtl/owned_id_pool_allocator_unit.sv
// top level of the owned id pool allocator
// an accepted word passes the input register and then the result register
// throughput: one request word per cycle while busy is low, set by the
//   combinational free search and parallel owner compare on all slot lanes
// reset: synchronous, clears every busy bit; busy is high for the first cycle
//   after reset and low from then on; the receiver cannot stall
module owned_id_pool_allocator_unit #(
    parameter int NUM_SLOTS = oipa_pkg::NUM_SLOTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  oipa_pkg::t_req i_req,
    output logic           o_valid,
    output oipa_pkg::t_rsp o_rsp
);
    import oipa_pkg::*;

    logic      r_ready;
    logic      r_req_vld;
    t_req      r_req;
    logic      r_rsp_vld;
    t_rsp      r_rsp;
    t_rsp      n_rsp;
    t_slot_cmd w_cmd;
    logic      w_accept;
    logic      w_free_found;
    logic [GRANT_W-1:0] w_free_slot;

    assign busy     = !r_ready;
    assign w_accept = start && !busy;

    // ready comes up in the cycle after reset is released
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b1;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else begin
            r_req_vld <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
    end

    // decode the held word into a slot command
    always_comb begin
        w_cmd         = '0;
        w_cmd.idx     = r_req.slot_index;
        w_cmd.ctx     = r_req.context_tag;
        w_cmd.owner   = r_req.owner_tag;
        w_cmd.grab    = r_req_vld && (r_req.kind == KIND_GRAB);
        w_cmd.rel     = r_req_vld && (r_req.kind == KIND_RELEASE);
        w_cmd.rel_own = r_req_vld && (r_req.kind == KIND_RELEASE_OWNER);
    end

    oipa_slot_file #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_slot_file (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_free_found (w_free_found),
        .o_free_slot  (w_free_slot)
    );

    // result word
    always_comb begin
        n_rsp.granted_slot = '0;
        n_rsp.status       = ST_OK;
        unique case (r_req.kind)
            KIND_GRAB: begin
                if (w_free_found) begin
                    n_rsp.granted_slot = w_free_slot;
                end else begin
                    n_rsp.status = ST_FULL;
                end
            end
            KIND_RELEASE, KIND_RELEASE_OWNER: begin
                n_rsp.status = ST_OK;
            end
            default: begin
                n_rsp.status = ST_INVALID;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_vld <= 1'b0;
        end else begin
            r_rsp_vld <= r_req_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_req_vld) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_rsp_vld;
    assign o_rsp   = r_rsp;

    // every held request produces a result strobe in the next cycle
    a_req_to_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req_vld |=> o_valid)
        else $error("held request did not produce a result");

    // a slot number is only reported on a successful grab
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.status != ST_OK)) |-> (o_rsp.granted_slot == '0))
        else $error("nonzero slot on a failed or invalid request");

    // full status only when the search found nothing
    a_full_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.status == ST_FULL)) |-> $past(!w_free_found))
        else $error("full status while a slot was free");

    // busy is raised right after reset
    a_busy_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

endmodule

>>> hw/rtl/oipa_slot_file.sv
// slot state: busy bits, owner lanes, context store and first-free search
module oipa_slot_file #(
    parameter int NUM_SLOTS = oipa_pkg::NUM_SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  oipa_pkg::t_slot_cmd          i_cmd,
    output logic                         o_free_found,
    output logic [oipa_pkg::GRANT_W-1:0] o_free_slot
);
    import oipa_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [NUM_SLOTS-1:0] r_busy;
    logic [NUM_SLOTS-1:0] n_busy;
    logic [OWNER_W-1:0]   r_owner   [NUM_SLOTS];
    logic [CTX_W-1:0]     r_ctx_mem [NUM_SLOTS];

    logic              w_found;
    logic [SLOT_W-1:0] w_free;
    logic              w_rel_hit;
    logic [SLOT_W-1:0] w_rel_slot;

    // lowest-numbered free slot
    always_comb begin
        w_found = 1'b0;
        w_free  = '0;
        for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
            if (!r_busy[s]) begin
                w_found = 1'b1;
                w_free  = SLOT_W'(s);
            end
        end
    end

    // single release only applies to slots inside the pool
    assign w_rel_hit  = i_cmd.rel &&
                        ({{(32 - SLOT_IDX_W){1'b0}}, i_cmd.idx} < 32'(NUM_SLOTS));
    assign w_rel_slot = SLOT_W'(i_cmd.idx);

    // per-slot busy update; a slot that is not busy reads as cleared
    always_comb begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
            n_busy[s] = r_busy[s];
            if (i_cmd.grab && w_found && (w_free == SLOT_W'(s))) begin
                n_busy[s] = 1'b1;
            end
            if (w_rel_hit && (w_rel_slot == SLOT_W'(s))) begin
                n_busy[s] = 1'b0;
            end
            if (i_cmd.rel_own && r_busy[s] && (r_owner[s] == i_cmd.owner)) begin
                n_busy[s] = 1'b0;
            end
        end
    end

    // busy bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
        end else begin
            r_busy <= n_busy;
        end
    end

    // owner and context recorded on grab
    always_ff @(posedge i_clk) begin
        if (i_cmd.grab && w_found) begin
            r_owner[w_free]   <= i_cmd.owner;
            r_ctx_mem[w_free] <= i_cmd.ctx;
        end
    end

    assign o_free_found = w_found;
    assign o_free_slot  = GRANT_W'(w_free);

endmodule
